@@ rtl/i2c_master_register_read_macros.svh @@
// Assertion macros for the I2C register-read master checker.
// No dependencies; the user supplies clk and rst in scope.
`ifndef I2C_MASTER_REGISTER_READ_MACROS_SVH
`define I2C_MASTER_REGISTER_READ_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define I2CMRR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cmrr: implication check failed");

// Next-cycle implication, disabled during reset.
`define I2CMRR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cmrr: next-cycle check failed");

`endif

@@ rtl/i2cmrr_pkg.sv @@
// Shared types and constants for the I2C single-register-read master.
// No dependencies.
package i2cmrr_pkg;

  localparam logic [15:0] PHASE_TICKS_RESET    = 16'd50;
  localparam logic [7:0]  ACK_POLL_LIMIT_RESET = 8'd250;
  localparam logic [7:0]  READ_FAIL_BYTE       = 8'hFF;

  // Register word index, taken from paddr[2].
  localparam logic REG_PHASE_TICKS    = 1'b0;
  localparam logic REG_ACK_POLL_LIMIT = 1'b1;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ADDR_WR  = 2'd1;
  localparam logic [1:0] ERR_REG      = 2'd2;
  localparam logic [1:0] ERR_ADDR_RD  = 2'd3;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Bus sequencer phases. Each byte transmit has three sub-phases per bit:
  // SCL low with data, SCL high, SCL low again before the next bit.
  typedef enum logic [27:0] {
    PH_IDLE  = 28'h0000001,
    PH_S1A   = 28'h0000002,
    PH_S1B   = 28'h0000004,
    PH_WTX0  = 28'h0000008,
    PH_WTX1  = 28'h0000010,
    PH_WTX2  = 28'h0000020,
    PH_WACK  = 28'h0000040,
    PH_WACKH = 28'h0000080,
    PH_RTX0  = 28'h0000100,
    PH_RTX1  = 28'h0000200,
    PH_RTX2  = 28'h0000400,
    PH_RACK  = 28'h0000800,
    PH_RACKH = 28'h0001000,
    PH_S2A   = 28'h0002000,
    PH_S2B   = 28'h0004000,
    PH_DTX0  = 28'h0008000,
    PH_DTX1  = 28'h0010000,
    PH_DTX2  = 28'h0020000,
    PH_DACK  = 28'h0040000,
    PH_DACKH = 28'h0080000,
    PH_RXL   = 28'h0100000,
    PH_RXH   = 28'h0200000,
    PH_RXK   = 28'h0400000,
    PH_NKL   = 28'h0800000,
    PH_NKH   = 28'h1000000,
    PH_SP1   = 28'h2000000,
    PH_SP2   = 28'h4000000,
    PH_SP3   = 28'h8000000
  } phase_t;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [7:0]  ack_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic [1:0] error_code;
  } result_t;

endpackage

@@ rtl/i2cmrr_regs.sv @@
// APB-style configuration registers for the I2C register-read master.
// Depends on i2cmrr_pkg.
module i2cmrr_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output i2cmrr_pkg::cfg_t    cfg
);

  logic [15:0] phase_ticks;
  logic [7:0]  ack_poll_limit;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks    <= i2cmrr_pkg::PHASE_TICKS_RESET;
      ack_poll_limit <= i2cmrr_pkg::ACK_POLL_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        i2cmrr_pkg::REG_PHASE_TICKS:    phase_ticks    <= pwdata[15:0];
        i2cmrr_pkg::REG_ACK_POLL_LIMIT: ack_poll_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      i2cmrr_pkg::REG_PHASE_TICKS:    prdata = {16'd0, phase_ticks};
      i2cmrr_pkg::REG_ACK_POLL_LIMIT: prdata = {24'd0, ack_poll_limit};
      default:                        prdata = 32'd0;
    endcase
  end

  assign cfg.phase_ticks    = phase_ticks;
  assign cfg.ack_poll_limit = ack_poll_limit;

endmodule

@@ rtl/i2cmrr_seq.sv @@
// Bus sequencer: state registers and the one-step update for one item.
// Depends on i2cmrr_pkg.
module i2cmrr_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  i2cmrr_pkg::item_t    item,
  input  i2cmrr_pkg::cfg_t     cfg,
  output i2cmrr_pkg::result_t  result
);

  i2cmrr_pkg::phase_t phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [15:0] delay_count, delay_count_next;
  logic [7:0]  poll_count, poll_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [6:0]  held_device, held_device_next;
  logic [7:0]  held_register, held_register_next;
  logic [1:0]  held_error, held_error_next;

  logic [15:0] delay_inc;
  logic [3:0]  bit_inc;
  logic        bit_last;
  logic        delay_due;
  logic        ack_high;
  logic        done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= i2cmrr_pkg::PH_IDLE;
      bit_count     <= 4'd0;
      delay_count   <= 16'd0;
      poll_count    <= 8'd0;
      shift_byte    <= 8'd0;
      held_device   <= 7'd0;
      held_register <= 8'd0;
      held_error    <= i2cmrr_pkg::ERR_NONE;
    end else if (step) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      delay_count   <= delay_count_next;
      poll_count    <= poll_count_next;
      shift_byte    <= shift_byte_next;
      held_device   <= held_device_next;
      held_register <= held_register_next;
      held_error    <= held_error_next;
    end
  end

  assign delay_inc = (delay_count < cfg.phase_ticks) ? delay_count + 16'd1 : delay_count;
  assign delay_due = delay_inc >= cfg.phase_ticks;
  assign bit_inc   = bit_count + 4'd1;
  assign bit_last  = bit_inc >= 4'd8;
  assign ack_high  = (phase == i2cmrr_pkg::PH_WACKH) || (phase == i2cmrr_pkg::PH_RACKH) ||
                     (phase == i2cmrr_pkg::PH_DACKH);

  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    delay_count_next   = delay_count;
    poll_count_next    = poll_count;
    shift_byte_next    = shift_byte;
    held_device_next   = held_device;
    held_register_next = held_register;
    held_error_next    = held_error;
    done               = 1'b0;

    if (phase == i2cmrr_pkg::PH_IDLE) begin
      if (item.req_type == i2cmrr_pkg::REQ_START) begin
        held_device_next   = item.dev_addr;
        held_register_next = item.reg_addr;
        held_error_next    = i2cmrr_pkg::ERR_NONE;
        poll_count_next    = 8'd0;
        bit_count_next     = 4'd0;
        delay_count_next   = 16'd0;
        shift_byte_next    = 8'd0;
        phase_next         = i2cmrr_pkg::PH_S1A;
      end
    end else if (item.req_type == i2cmrr_pkg::REQ_TICK) begin
      delay_count_next = delay_inc;
      if (delay_due && ack_high && item.sda_in) begin
        // No acknowledge yet: keep polling with SCL high, or abort with a stop.
        if (poll_count >= cfg.ack_poll_limit) begin
          if (phase == i2cmrr_pkg::PH_WACKH) begin
            held_error_next = i2cmrr_pkg::ERR_ADDR_WR;
          end else if (phase == i2cmrr_pkg::PH_RACKH) begin
            held_error_next = i2cmrr_pkg::ERR_REG;
          end else begin
            held_error_next = i2cmrr_pkg::ERR_ADDR_RD;
          end
          delay_count_next = 16'd0;
          phase_next       = i2cmrr_pkg::PH_SP1;
        end else begin
          poll_count_next = poll_count + 8'd1;
        end
      end else if (delay_due) begin
        delay_count_next = 16'd0;
        unique case (phase)
          i2cmrr_pkg::PH_S1A:  phase_next = i2cmrr_pkg::PH_S1B;
          i2cmrr_pkg::PH_S1B: begin
            shift_byte_next = {held_device, 1'b0};
            bit_count_next  = 4'd0;
            phase_next      = i2cmrr_pkg::PH_WTX0;
          end
          i2cmrr_pkg::PH_WTX0: phase_next = i2cmrr_pkg::PH_WTX1;
          i2cmrr_pkg::PH_WTX1: phase_next = i2cmrr_pkg::PH_WTX2;
          i2cmrr_pkg::PH_WTX2: begin
            shift_byte_next = {shift_byte[6:0], 1'b0};
            bit_count_next  = bit_inc;
            phase_next      = bit_last ? i2cmrr_pkg::PH_WACK : i2cmrr_pkg::PH_WTX0;
          end
          i2cmrr_pkg::PH_WACK: begin
            poll_count_next = 8'd0;
            phase_next      = i2cmrr_pkg::PH_WACKH;
          end
          i2cmrr_pkg::PH_WACKH: begin
            shift_byte_next = held_register;
            bit_count_next  = 4'd0;
            phase_next      = i2cmrr_pkg::PH_RTX0;
          end
          i2cmrr_pkg::PH_RTX0: phase_next = i2cmrr_pkg::PH_RTX1;
          i2cmrr_pkg::PH_RTX1: phase_next = i2cmrr_pkg::PH_RTX2;
          i2cmrr_pkg::PH_RTX2: begin
            shift_byte_next = {shift_byte[6:0], 1'b0};
            bit_count_next  = bit_inc;
            phase_next      = bit_last ? i2cmrr_pkg::PH_RACK : i2cmrr_pkg::PH_RTX0;
          end
          i2cmrr_pkg::PH_RACK: begin
            poll_count_next = 8'd0;
            phase_next      = i2cmrr_pkg::PH_RACKH;
          end
          i2cmrr_pkg::PH_RACKH: phase_next = i2cmrr_pkg::PH_S2A;
          i2cmrr_pkg::PH_S2A:   phase_next = i2cmrr_pkg::PH_S2B;
          i2cmrr_pkg::PH_S2B: begin
            shift_byte_next = {held_device, 1'b1};
            bit_count_next  = 4'd0;
            phase_next      = i2cmrr_pkg::PH_DTX0;
          end
          i2cmrr_pkg::PH_DTX0: phase_next = i2cmrr_pkg::PH_DTX1;
          i2cmrr_pkg::PH_DTX1: phase_next = i2cmrr_pkg::PH_DTX2;
          i2cmrr_pkg::PH_DTX2: begin
            shift_byte_next = {shift_byte[6:0], 1'b0};
            bit_count_next  = bit_inc;
            phase_next      = bit_last ? i2cmrr_pkg::PH_DACK : i2cmrr_pkg::PH_DTX0;
          end
          i2cmrr_pkg::PH_DACK: begin
            poll_count_next = 8'd0;
            phase_next      = i2cmrr_pkg::PH_DACKH;
          end
          i2cmrr_pkg::PH_DACKH: begin
            shift_byte_next = 8'd0;
            bit_count_next  = 4'd0;
            phase_next      = i2cmrr_pkg::PH_RXL;
          end
          i2cmrr_pkg::PH_RXL: phase_next = i2cmrr_pkg::PH_RXH;
          i2cmrr_pkg::PH_RXH: begin
            shift_byte_next = {shift_byte[6:0], item.sda_in};
            phase_next      = i2cmrr_pkg::PH_RXK;
          end
          i2cmrr_pkg::PH_RXK: begin
            bit_count_next = bit_inc;
            phase_next     = bit_last ? i2cmrr_pkg::PH_NKL : i2cmrr_pkg::PH_RXL;
          end
          i2cmrr_pkg::PH_NKL: phase_next = i2cmrr_pkg::PH_NKH;
          i2cmrr_pkg::PH_NKH: phase_next = i2cmrr_pkg::PH_SP1;
          i2cmrr_pkg::PH_SP1: phase_next = i2cmrr_pkg::PH_SP2;
          i2cmrr_pkg::PH_SP2: phase_next = i2cmrr_pkg::PH_SP3;
          i2cmrr_pkg::PH_SP3: begin
            phase_next = i2cmrr_pkg::PH_IDLE;
            done       = 1'b1;
          end
          default: phase_next = i2cmrr_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // Bus levels follow the updated phase.
  always_comb begin
    result.scl_level    = 1'b1;
    result.sda_pull_low = 1'b0;
    unique case (phase_next) inside
      i2cmrr_pkg::PH_WTX0, i2cmrr_pkg::PH_WTX2, i2cmrr_pkg::PH_RTX0, i2cmrr_pkg::PH_RTX2,
      i2cmrr_pkg::PH_DTX0, i2cmrr_pkg::PH_DTX2: begin
        result.scl_level    = 1'b0;
        result.sda_pull_low = ~shift_byte_next[7];
      end
      i2cmrr_pkg::PH_WTX1, i2cmrr_pkg::PH_RTX1, i2cmrr_pkg::PH_DTX1: begin
        result.sda_pull_low = ~shift_byte_next[7];
      end
      i2cmrr_pkg::PH_S1B, i2cmrr_pkg::PH_S2B, i2cmrr_pkg::PH_SP2: begin
        result.sda_pull_low = 1'b1;
      end
      i2cmrr_pkg::PH_WACK, i2cmrr_pkg::PH_RACK, i2cmrr_pkg::PH_DACK,
      i2cmrr_pkg::PH_RXL, i2cmrr_pkg::PH_NKL: begin
        result.scl_level = 1'b0;
      end
      i2cmrr_pkg::PH_SP1: begin
        result.scl_level    = 1'b0;
        result.sda_pull_low = 1'b1;
      end
      default: ;
    endcase
  end

  assign result.busy_res   = phase_next != i2cmrr_pkg::PH_IDLE;
  assign result.done_res   = done;
  assign result.read_data  = !done ? 8'd0 :
                             (held_error_next != i2cmrr_pkg::ERR_NONE) ?
                             i2cmrr_pkg::READ_FAIL_BYTE : shift_byte_next;
  assign result.error_code = done ? held_error_next : i2cmrr_pkg::ERR_NONE;

endmodule

@@ rtl/i2c_master_register_read.sv @@
// Top level of the I2C single-register-read master: input and result registers.
// Depends on i2cmrr_pkg, i2cmrr_regs and i2cmrr_seq.
//
//   Channel  Handshake              Contents
//   in       in_valid / in_ready    req_type, dev_addr, reg_addr, sda_in
//   out      out_valid / out_ready  scl_level, sda_pull_low, busy_res, done_res,
//                                   read_data, error_code
//   cfg      APB psel/penable/...   phase_ticks (0x0), ack_poll_limit (0x4)
//
// Each transaction passes through the input register, then through the
// sequencer step into the result register.
// One transaction per cycle is sustained while the output is not stalled; the sequencer state is updated by each step.
// Reset is synchronous and clears the valid flags, sequencer state and configuration registers.
// A stalled output holds the result; the input register keeps taking items while
// the result register can drain.
module i2c_master_register_read (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [6:0]  dev_addr,
  input  logic [7:0]  reg_addr,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_level,
  output logic        sda_pull_low,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_data,
  output logic [1:0]  error_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  i2cmrr_pkg::cfg_t    cfg;
  i2cmrr_pkg::item_t   item;
  i2cmrr_pkg::result_t result;
  i2cmrr_pkg::result_t out_data;
  logic                item_valid;
  logic                out_free;
  logic                step;

  assign out_free = !out_valid || out_ready;
  assign step     = item_valid && out_free;
  assign in_ready = !item_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.req_type <= req_type;
      item.dev_addr <= dev_addr;
      item.reg_addr <= reg_addr;
      item.sda_in   <= sda_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

  i2cmrr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2cmrr_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  assign scl_level    = out_data.scl_level;
  assign sda_pull_low = out_data.sda_pull_low;
  assign busy_res     = out_data.busy_res;
  assign done_res     = out_data.done_res;
  assign read_data    = out_data.read_data;
  assign error_code   = out_data.error_code;

endmodule

@@ rtl/i2cmrr_checker.sv @@
// Port-level checker for the I2C register-read master, bound to the top level.
// Depends on i2c_master_register_read_macros.svh.
`include "i2c_master_register_read_macros.svh"

module i2cmrr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        scl_level,
  input logic        sda_pull_low,
  input logic        busy_res,
  input logic        done_res,
  input logic [7:0]  read_data,
  input logic [1:0]  error_code,
  input logic        pready
);

  // A stalled result keeps its contents.
  `I2CMRR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(done_res) && $stable(scl_level))

  // The transaction that ends a read leaves the block idle.
  `I2CMRR_ASSERT_IMP(a_done_idle, out_valid && done_res, !busy_res)

  // Data and error fields are only nonzero on the final result.
  `I2CMRR_ASSERT_IMP(a_quiet_fields, out_valid && !done_res, read_data == 8'd0 && error_code == 2'd0)

  // An idle master leaves the bus released.
  `I2CMRR_ASSERT_IMP(a_idle_bus, out_valid && !busy_res, scl_level && !sda_pull_low)

endmodule

bind i2c_master_register_read i2cmrr_checker u_i2cmrr_checker (.*);

@@ verif/testbench.sv @@
// Self-checking testbench for the I2C single-register-read master.
// Depends on i2cmrr_pkg and i2c_master_register_read; predicts every result
// from its own copy of the bus sequencer.
module testbench;
  import i2cmrr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [6:0]  dev_addr;
  logic [7:0]  reg_addr;
  logic        sda_in;
  logic        out_valid;
  logic        out_ready;
  logic        scl_level;
  logic        sda_pull_low;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  read_data;
  logic [1:0]  error_code;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_register_read u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .dev_addr(dev_addr), .reg_addr(reg_addr), .sda_in(sda_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .scl_level(scl_level), .sda_pull_low(sda_pull_low), .busy_res(busy_res),
    .done_res(done_res), .read_data(read_data), .error_code(error_code),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predicted sequencer state and configuration.
  phase_t      seq_phase;
  logic [3:0]  seq_bits;
  logic [15:0] seq_delay;
  logic [7:0]  seq_polls;
  logic [7:0]  seq_shift;
  logic [6:0]  seq_dev;
  logic [7:0]  seq_reg;
  logic [1:0]  seq_err;
  logic [15:0] cfg_ticks;
  logic [7:0]  cfg_poll_limit;

  result_t     expected_bus_q[$];
  int          bad_results;
  int          cycle_count;
  int          hold_until_cycle;
  bit          sender_gaps_on;
  bit          receiver_stalls_on;

  // Which acknowledge the simulated target refuses, and for how many ticks.
  logic [1:0]  refuse_ack;
  int          refuse_ticks_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (cycle_count < hold_until_cycle) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(receiver_stalls_on && $urandom_range(99) < 20);
    end
  end

  function automatic void load_byte(input phase_t first, input logic [7:0] value);
    seq_shift = value;
    seq_bits = 4'd0;
    seq_phase = first;
  endfunction

  // Moves the sequencer on once the current level has been held long enough.
  function automatic logic advance_sequencer(input logic sda);
    logic finished;
    finished = 1'b0;
    seq_delay = 16'd0;
    case (seq_phase)
      PH_WTX0: seq_phase = PH_WTX1;
      PH_WTX1: seq_phase = PH_WTX2;
      PH_RTX0: seq_phase = PH_RTX1;
      PH_RTX1: seq_phase = PH_RTX2;
      PH_DTX0: seq_phase = PH_DTX1;
      PH_DTX1: seq_phase = PH_DTX2;
      PH_WTX2, PH_RTX2, PH_DTX2: begin
        seq_shift = seq_shift << 1;
        seq_bits = seq_bits + 4'd1;
        case (seq_phase)
          PH_WTX2: seq_phase = (seq_bits >= 4'd8) ? PH_WACK : PH_WTX0;
          PH_RTX2: seq_phase = (seq_bits >= 4'd8) ? PH_RACK : PH_RTX0;
          default: seq_phase = (seq_bits >= 4'd8) ? PH_DACK : PH_DTX0;
        endcase
      end
      PH_S1A: seq_phase = PH_S1B;
      PH_S1B: load_byte(PH_WTX0, {seq_dev, 1'b0});
      PH_WACK: begin
        seq_polls = 8'd0;
        seq_phase = PH_WACKH;
      end
      PH_RACK: begin
        seq_polls = 8'd0;
        seq_phase = PH_RACKH;
      end
      PH_DACK: begin
        seq_polls = 8'd0;
        seq_phase = PH_DACKH;
      end
      PH_WACKH: load_byte(PH_RTX0, seq_reg);
      PH_RACKH: seq_phase = PH_S2A;
      PH_S2A: seq_phase = PH_S2B;
      PH_S2B: load_byte(PH_DTX0, {seq_dev, 1'b1});
      PH_DACKH: begin
        seq_shift = 8'd0;
        seq_bits = 4'd0;
        seq_phase = PH_RXL;
      end
      PH_RXL: seq_phase = PH_RXH;
      PH_RXH: begin
        seq_shift = {seq_shift[6:0], sda};
        seq_phase = PH_RXK;
      end
      PH_RXK: begin
        seq_bits = seq_bits + 4'd1;
        seq_phase = (seq_bits >= 4'd8) ? PH_NKL : PH_RXL;
      end
      PH_NKL: seq_phase = PH_NKH;
      PH_NKH: seq_phase = PH_SP1;
      PH_SP1: seq_phase = PH_SP2;
      PH_SP2: seq_phase = PH_SP3;
      PH_SP3: begin
        seq_phase = PH_IDLE;
        finished = 1'b1;
      end
      default: seq_phase = PH_IDLE;
    endcase
    return finished;
  endfunction

  function automatic result_t predict_bus_step(input logic req, input logic [6:0] dev,
                                               input logic [7:0] reg_idx, input logic sda);
    result_t r;
    logic    finished;
    finished = 1'b0;
    if (seq_phase == PH_IDLE) begin
      if (req == REQ_START) begin
        seq_dev = dev;
        seq_reg = reg_idx;
        seq_err = ERR_NONE;
        seq_polls = 8'd0;
        seq_bits = 4'd0;
        seq_delay = 16'd0;
        seq_shift = 8'd0;
        seq_phase = PH_S1A;
      end
    end else if (req == REQ_TICK) begin
      if (seq_delay < cfg_ticks) seq_delay = seq_delay + 16'd1;
      if (seq_delay >= cfg_ticks) begin
        if (seq_phase == PH_WACKH || seq_phase == PH_RACKH || seq_phase == PH_DACKH) begin
          if (!sda) begin
            finished = advance_sequencer(sda);
          end else if (seq_polls >= cfg_poll_limit) begin
            seq_err = (seq_phase == PH_WACKH) ? ERR_ADDR_WR :
                      (seq_phase == PH_RACKH) ? ERR_REG : ERR_ADDR_RD;
            seq_delay = 16'd0;
            seq_phase = PH_SP1;
          end else begin
            seq_polls = seq_polls + 8'd1;
          end
        end else begin
          finished = advance_sequencer(sda);
        end
      end
    end

    r.scl_level = 1'b1;
    r.sda_pull_low = 1'b0;
    case (seq_phase)
      PH_WTX0, PH_WTX2, PH_RTX0, PH_RTX2, PH_DTX0, PH_DTX2: begin
        r.scl_level = 1'b0;
        r.sda_pull_low = ~seq_shift[7];
      end
      PH_WTX1, PH_RTX1, PH_DTX1: r.sda_pull_low = ~seq_shift[7];
      PH_S1B, PH_S2B, PH_SP2: r.sda_pull_low = 1'b1;
      PH_WACK, PH_RACK, PH_DACK, PH_RXL, PH_NKL: r.scl_level = 1'b0;
      PH_SP1: begin
        r.scl_level = 1'b0;
        r.sda_pull_low = 1'b1;
      end
      default: ;
    endcase
    r.busy_res = (seq_phase != PH_IDLE);
    r.done_res = finished;
    r.read_data = !finished ? 8'd0 : (seq_err != ERR_NONE) ? READ_FAIL_BYTE : seq_shift;
    r.error_code = finished ? seq_err : ERR_NONE;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    bad_results++;
    if (bad_results <= 10) begin
      $display("mismatch at cycle %0d: %s expected %0d, got %0d", cycle_count, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bus_q.size() == 0) begin
        report_mismatch("unexpected transaction, pending", 0, 1);
      end else begin
        want = expected_bus_q.pop_front();
        if (scl_level !== want.scl_level)
          report_mismatch("scl_level", want.scl_level, scl_level);
        if (sda_pull_low !== want.sda_pull_low)
          report_mismatch("sda_pull_low", want.sda_pull_low, sda_pull_low);
        if (busy_res !== want.busy_res)
          report_mismatch("busy_res", want.busy_res, busy_res);
        if (done_res !== want.done_res)
          report_mismatch("done_res", want.done_res, done_res);
        if (read_data !== want.read_data)
          report_mismatch("read_data", want.read_data, read_data);
        if (error_code !== want.error_code)
          report_mismatch("error_code", want.error_code, error_code);
      end
    end
  end

  // Offers one item and records its expected result once it is accepted.
  task automatic offer_item(input logic req, input logic [6:0] dev,
                            input logic [7:0] reg_idx, input logic sda);
    int gap;
    gap = 0;
    if (sender_gaps_on && $urandom_range(99) < 20) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    dev_addr <= dev;
    reg_addr <= reg_idx;
    sda_in <= sda;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_bus_q.push_back(predict_bus_step(req, dev, reg_idx, sda));
  endtask

  // Plays the target: acknowledges unless told to refuse this acknowledge, but now and then answers at random.
  task automatic offer_tick();
    logic sda;
    sda = $urandom_range(1);
    if (seq_phase == PH_WACKH || seq_phase == PH_RACKH || seq_phase == PH_DACKH) begin
      if ($urandom_range(99) < 5) begin
        sda = $urandom_range(1);
      end else if (refuse_ticks_left > 0 &&
                   refuse_ack == ((seq_phase == PH_WACKH) ? ERR_ADDR_WR :
                                  (seq_phase == PH_RACKH) ? ERR_REG : ERR_ADDR_RD)) begin
        sda = 1'b1;
        refuse_ticks_left--;
      end else begin
        sda = 1'b0;
      end
    end
    offer_item(REQ_TICK, $urandom_range(127), $urandom_range(255), sda);
  endtask

  task automatic start_read(input logic [6:0] dev, input logic [7:0] reg_idx,
                            input logic [1:0] refuse, input int refuse_ticks);
    refuse_ack = refuse;
    refuse_ticks_left = refuse_ticks;
    offer_item(REQ_START, dev, reg_idx, $urandom_range(1));
  endtask

  task automatic run_to_idle();
    while (seq_phase != PH_IDLE) offer_tick();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_bus_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes one register, then reads it back in the following transfer.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) report_mismatch("register read-back", value, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_timing(input logic [15:0] ticks, input logic [7:0] limit);
    wait_drained();
    write_reg(REG_PHASE_TICKS, {16'd0, ticks});
    cfg_ticks = ticks;
    write_reg(REG_ACK_POLL_LIMIT, {24'd0, limit});
    cfg_poll_limit = limit;
  endtask

  task automatic test_default_timing_read();
    repeat (3) offer_item(REQ_TICK, 7'h7F, 8'hFF, 1'b1);
    start_read(7'h7F, 8'h00, ERR_NONE, 0);
    repeat (2) offer_tick();
    // A request during a transfer must be dropped without side effects.
    offer_item(REQ_START, 7'h00, 8'hFF, 1'b0);
    run_to_idle();
  endtask

  task automatic test_fastest_read();
    set_timing(16'd1, 8'd1);
    start_read(7'h00, 8'hFF, ERR_NONE, 0);
    run_to_idle();
    start_read(7'h55, 8'hAA, ERR_ADDR_RD, 1);
    run_to_idle();
  endtask

  task automatic test_zero_settings();
    set_timing(16'd0, 8'd0);
    start_read(7'h2A, 8'h55, ERR_ADDR_WR, 1);
    run_to_idle();
    start_read(7'h15, 8'h3C, ERR_NONE, 0);
    run_to_idle();
  endtask

  task automatic test_register_nack_and_late_ack();
    set_timing(16'd2, 8'd3);
    start_read(7'h40, 8'h80, ERR_REG, 50);
    run_to_idle();
    start_read(7'h01, 8'h01, ERR_ADDR_RD, 3);
    run_to_idle();
  endtask

  task automatic test_poll_limit_max();
    set_timing(16'd1, 8'd255);
    start_read(7'h7F, 8'hFF, ERR_ADDR_RD, 300);
    run_to_idle();
    start_read(7'h00, 8'h00, ERR_ADDR_WR, 200);
    run_to_idle();
  endtask

  task automatic test_output_backpressure();
    set_timing(16'd1, 8'd2);
    sender_gaps_on = 1'b0;
    receiver_stalls_on = 1'b0;
    hold_until_cycle = cycle_count + 150;
    start_read($urandom_range(127), $urandom_range(255), ERR_NONE, 0);
    run_to_idle();
    wait_drained();
    start_read($urandom_range(127), $urandom_range(255), ERR_REG, 2);
    run_to_idle();
  endtask

  task automatic test_random_transfers(input logic [15:0] ticks, input logic [7:0] limit,
                                       input bit idling, input int wanted);
    int         counted;
    logic [1:0] refuse;
    set_timing(ticks, limit);
    sender_gaps_on = idling;
    receiver_stalls_on = idling;
    counted = 0;
    while (counted < wanted) begin
      if (seq_phase == PH_IDLE) begin
        if ($urandom_range(99) < 60) begin
          refuse = $urandom_range(3);
          if ($urandom_range(1)) refuse = ERR_NONE;
          start_read($urandom_range(127), $urandom_range(255), refuse, $urandom_range(12));
          counted++;
        end else begin
          offer_item(REQ_TICK, $urandom_range(127), $urandom_range(255), $urandom_range(1));
        end
      end else if ($urandom_range(99) < 2) begin
        offer_item(REQ_START, $urandom_range(127), $urandom_range(255), $urandom_range(1));
      end else begin
        offer_tick();
        counted++;
      end
    end
    run_to_idle();
  endtask

  // The transfer cannot finish within the ticks offered at this setting, so it is left running at the end.
  task automatic test_slowest_timing();
    set_timing(16'd65535, 8'd255);
    start_read($urandom_range(127), $urandom_range(255), ERR_NONE, 0);
    repeat (30) offer_tick();
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= REQ_TICK;
    dev_addr <= 7'd0;
    reg_addr <= 8'd0;
    sda_in <= 1'b1;
    out_ready <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 3'd0;
    pwdata <= 32'd0;
    cycle_count = 0;
    hold_until_cycle = 0;
    bad_results = 0;
    sender_gaps_on = 1'b1;
    receiver_stalls_on = 1'b1;
    refuse_ack = ERR_NONE;
    refuse_ticks_left = 0;
    seq_phase = PH_IDLE;
    seq_bits = 4'd0;
    seq_delay = 16'd0;
    seq_polls = 8'd0;
    seq_shift = 8'd0;
    seq_dev = 7'd0;
    seq_reg = 8'd0;
    seq_err = ERR_NONE;
    cfg_ticks = PHASE_TICKS_RESET;
    cfg_poll_limit = ACK_POLL_LIMIT_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_default_timing_read();
    test_fastest_read();
    test_zero_settings();
    test_register_nack_and_late_ack();
    test_poll_limit_max();
    test_output_backpressure();
    test_random_transfers(16'd1, 8'd2, 1'b1, 300);
    test_random_transfers(16'd0, 8'd0, 1'b0, 300);
    test_random_transfers(16'd3, 8'd5, 1'b1, 300);
    sender_gaps_on = 1'b1;
    receiver_stalls_on = 1'b1;
    test_slowest_timing();

    wait_drained();
    repeat (8) @(posedge clk);
    if (expected_bus_q.size() != 0) bad_results++;
    if (bad_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
